@@ rtl/core/spa_pkg.sv @@
// Shared types and constants of the simple polygon area block.
`timescale 1ns / 1ps
package spa_pkg;
   localparam int COORD_W = 24;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int ACC_W = 59;
   localparam int AREA_W = 50;
   localparam int MAX_VERTICES_DEF = 1024;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      ST_SIMPLE   = 2'd0,
      ST_FEW      = 2'd1,
      ST_CROSS    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AREA,
      S_AREA_WAIT,
      S_SCAN,
      S_READ,
      S_ORIENT,
      S_ORIENT_WAIT,
      S_DECIDE,
      S_RESULT
   } state_type;

   typedef struct packed {
      acc_op_type op;
      logic       capture;
      logic [1:0] tag;
      coord_type  u1;
      coord_type  u2;
      coord_type  v1;
      coord_type  v2;
   } mac_req_type;

   typedef struct packed {
      logic             done;
      logic [1:0]       tag;
      logic [ACC_W-1:0] acc;
   } mac_rsp_type;
endpackage

@@ rtl/core/spa_if.sv @@
// Request and response channel interfaces of the simple polygon area block.
`timescale 1ns / 1ps
interface spa_req_if import spa_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   logic      last_vertex;
   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface spa_rsp_if import spa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [AREA_W-1:0] doubled_area;
   modport source (output valid, status, doubled_area, input ready);
   modport sink (input valid, status, doubled_area, output ready);
endinterface

@@ rtl/core/spa_store.sv @@
// Vertex store: one write port and one registered read port.
`timescale 1ns / 1ps
module spa_store import spa_pkg::*; #(
   parameter int DEPTH = MAX_VERTICES_DEF,
   parameter int AW = $clog2(MAX_VERTICES_DEF)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [2*COORD_W-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [2*COORD_W-1:0] rd_data
);
   logic [2*COORD_W-1:0] mem [DEPTH];
   logic [2*COORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/spa_mac.sv @@
// Shared difference-multiply-accumulate unit; the differences, the product and the sum are each registered.
`timescale 1ns / 1ps
module spa_mac import spa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mac_req_type req,
   output mac_rsp_type rsp
);
   logic signed [DIFF_W-1:0] a_ff, b_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   acc_op_type               op1_ff, op2_ff;
   logic                     cap1_ff, cap2_ff, done_ff;
   logic [1:0]               tag1_ff, tag2_ff, tag3_ff;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_ext = ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      a_ff    <= DIFF_W'(req.u1) - DIFF_W'(req.u2);
      b_ff    <= DIFF_W'(req.v1) - DIFF_W'(req.v2);
      prod_ff <= a_ff * b_ff;
      tag1_ff <= req.tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      case (op2_ff)
         ACC_LOAD: acc_ff <= prod_ext;
         ACC_ADD:  acc_ff <= acc_ff + prod_ext;
         ACC_SUB:  acc_ff <= acc_ff - prod_ext;
         default:  acc_ff <= acc_ff;
      endcase
      if (reset) begin
         op1_ff  <= ACC_NONE;
         op2_ff  <= ACC_NONE;
         cap1_ff <= 1'b0;
         cap2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         op1_ff  <= req.op;
         op2_ff  <= op1_ff;
         cap1_ff <= req.capture && (req.op != ACC_NONE);
         cap2_ff <= cap1_ff;
         done_ff <= cap2_ff;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.tag  = tag3_ff;
   assign rsp.acc  = acc_ff;
endmodule

@@ rtl/core/simple_polygon_area.sv @@
// Top level of the simple polygon area block: sequencer, store and shared multiplier.
`timescale 1ns / 1ps
//
// Channel  Modport  Transaction
// req_ch   sink     one vertex (vertex_x, vertex_y, last_vertex)
// rsp_ch   source   one result (status, doubled_area) after the closing vertex
//
// A vertex that does not close the polygon is accepted and stored, then its
// two shoelace products go to the shared multiplier and the block waits for
// the sum. The first vertex of a polygon is only accepted and stored. The
// closing vertex adds the final terms, then the block tests the non-adjacent
// edge pairs in turn until one crosses; the single multiplier forms the
// eight products of each test.
// Reset is synchronous and needs no clearing pass; store entries are only
// read after they were written. While a result waits on rsp_ch the block
// does not accept a new vertex.
module simple_polygon_area import spa_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input logic      clock,
   input logic      reset,
   spa_req_if.sink   req_ch,
   spa_rsp_if.source rsp_ch
);
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = CNT_W + 1;

   // Sequencer state and the polygon being loaded.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;
   logic [2:0]        step_ff, step_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in;
   status_type        status_ff, status_in;
   logic [AREA_W-1:0] area_ff, area_in;

   // Vertices kept in registers for the shoelace terms.
   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type first_x_ff, first_x_in, first_y_ff, first_y_in;

   // The edge pair under test and the signs of their orientations.
   coord_type p1x_ff, p1x_in, p1y_ff, p1y_in, p2x_ff, p2x_in, p2y_ff, p2y_in;
   coord_type q1x_ff, q1x_in, q1y_ff, q1y_in, q2x_ff, q2x_in, q2y_ff, q2y_in;
   logic [3:0] dneg_ff, dneg_in, dzero_ff, dzero_in;

   logic                 accept, full, wr_en, rd_en;
   logic [AW-1:0]        rd_addr;
   logic [2*COORD_W-1:0] rd_data;
   coord_type            rd_x, rd_y;
   mac_req_type          mac_req;
   mac_rsp_type          mac_rsp;
   logic [IDX_W-1:0]     n_idx, j_next, addr_idx;
   logic [ACC_W-1:0]     mag;
   coord_type            ax, ay, bx, by, ox, oy;
   logic                 straddle, touch;

   function automatic logic in_range(coord_type v, coord_type a, coord_type b);
      return ((v >= a) && (v <= b)) || ((v >= b) && (v <= a));
   endfunction

   spa_store #(.DEPTH(MAX_VERTICES), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_ch.vertex_y, req_ch.vertex_x}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spa_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .rsp   (mac_rsp)
   );

   assign rd_x = rd_data[COORD_W-1:0];
   assign rd_y = rd_data[2*COORD_W-1:COORD_W];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign full = (count_ff == CNT_W'(MAX_VERTICES));
   assign wr_en = accept && !full;

   assign rsp_ch.valid = (state_ff == S_RESULT);
   assign rsp_ch.status = status_ff;
   assign rsp_ch.doubled_area = (status_ff == ST_SIMPLE) ? area_ff : '0;

   assign n_idx = IDX_W'(count_ff);
   assign j_next = j_ff + IDX_W'(1);

   // Magnitude of the two's complement shoelace sum.
   assign mag = mac_rsp.acc[ACC_W-1] ? (~mac_rsp.acc + ACC_W'(1)) : mac_rsp.acc;

   // Orientation triple (a, b, o) for the product pair now being issued.
   always_comb begin
      case (step_ff[2:1])
         2'd0: begin
            ax = p1x_ff; ay = p1y_ff; bx = p2x_ff; by = p2y_ff; ox = q1x_ff; oy = q1y_ff;
         end
         2'd1: begin
            ax = p1x_ff; ay = p1y_ff; bx = p2x_ff; by = p2y_ff; ox = q2x_ff; oy = q2y_ff;
         end
         2'd2: begin
            ax = q1x_ff; ay = q1y_ff; bx = q2x_ff; by = q2y_ff; ox = p1x_ff; oy = p1y_ff;
         end
         default: begin
            ax = q1x_ff; ay = q1y_ff; bx = q2x_ff; by = q2y_ff; ox = p2x_ff; oy = p2y_ff;
         end
      endcase
   end

   // Proper crossing needs both edges to straddle each other; a zero
   // orientation counts when the point lies in the other edge's box.
   always_comb begin
      straddle = ((dneg_ff[0] && !dneg_ff[1] && !dzero_ff[1]) ||
                  (!dneg_ff[0] && !dzero_ff[0] && dneg_ff[1])) &&
                 ((dneg_ff[2] && !dneg_ff[3] && !dzero_ff[3]) ||
                  (!dneg_ff[2] && !dzero_ff[2] && dneg_ff[3]));
      touch = (dzero_ff[0] && in_range(q1x_ff, p1x_ff, p2x_ff) &&
               in_range(q1y_ff, p1y_ff, p2y_ff)) ||
              (dzero_ff[1] && in_range(q2x_ff, p1x_ff, p2x_ff) &&
               in_range(q2y_ff, p1y_ff, p2y_ff)) ||
              (dzero_ff[2] && in_range(p1x_ff, q1x_ff, q2x_ff) &&
               in_range(p1y_ff, q1y_ff, q2y_ff)) ||
              (dzero_ff[3] && in_range(p2x_ff, q1x_ff, q2x_ff) &&
               in_range(p2y_ff, q1y_ff, q2y_ff));
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      last_in = last_ff;
      step_in = step_ff;
      i_in = i_ff;
      j_in = j_ff;
      status_in = status_ff;
      area_in = area_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      cur_x_in = cur_x_ff; cur_y_in = cur_y_ff;
      first_x_in = first_x_ff; first_y_in = first_y_ff;
      p1x_in = p1x_ff; p1y_in = p1y_ff; p2x_in = p2x_ff; p2y_in = p2y_ff;
      q1x_in = q1x_ff; q1y_in = q1y_ff; q2x_in = q2x_ff; q2y_in = q2y_ff;
      dneg_in = dneg_ff;
      dzero_in = dzero_ff;
      mac_req = '0;
      mac_req.op = ACC_NONE;
      rd_en = 1'b0;
      addr_idx = i_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (full) begin
                  // The store is full: the vertex is dropped.
                  ovf_in = 1'b1;
                  if (req_ch.last_vertex) begin
                     status_in = ST_OVERFLOW;
                     state_in = S_RESULT;
                  end
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  prev_x_in = cur_x_ff;
                  prev_y_in = cur_y_ff;
                  cur_x_in = req_ch.vertex_x;
                  cur_y_in = req_ch.vertex_y;
                  last_in = req_ch.last_vertex;
                  step_in = '0;
                  if (count_ff == '0) begin
                     first_x_in = req_ch.vertex_x;
                     first_y_in = req_ch.vertex_y;
                  end
                  if (req_ch.last_vertex && (ovf_ff || (count_ff < CNT_W'(2)))) begin
                     status_in = ovf_ff ? ST_OVERFLOW : ST_FEW;
                     state_in = S_RESULT;
                  end else if (count_ff != '0) begin
                     state_in = S_AREA;
                  end
               end
            end
         end
         S_AREA: begin
            step_in = step_ff + 3'd1;
            case (step_ff[1:0])
               2'd0: begin
                  mac_req.u1 = prev_x_ff;
                  mac_req.v1 = cur_y_ff;
                  mac_req.op = (count_ff == CNT_W'(2)) ? ACC_LOAD : ACC_ADD;
               end
               2'd1: begin
                  mac_req.u1 = prev_y_ff;
                  mac_req.v1 = cur_x_ff;
                  mac_req.op = ACC_SUB;
                  mac_req.capture = !last_ff;
                  if (!last_ff) begin
                     state_in = S_AREA_WAIT;
                  end
               end
               2'd2: begin
                  mac_req.u1 = cur_x_ff;
                  mac_req.v1 = first_y_ff;
                  mac_req.op = ACC_ADD;
               end
               default: begin
                  mac_req.u1 = cur_y_ff;
                  mac_req.v1 = first_x_ff;
                  mac_req.op = ACC_SUB;
                  mac_req.capture = 1'b1;
                  state_in = S_AREA_WAIT;
               end
            endcase
         end
         S_AREA_WAIT: begin
            if (mac_rsp.done) begin
               if (last_ff) begin
                  area_in = mag[AREA_W-1:0];
                  i_in = '0;
                  j_in = IDX_W'(2);
                  state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            // Steps the pair indices to the next non-adjacent edge pair; none left means simple.
            if (j_ff >= n_idx) begin
               if ((i_ff + IDX_W'(3)) >= n_idx) begin
                  status_in = ST_SIMPLE;
                  state_in = S_RESULT;
               end else begin
                  i_in = i_ff + IDX_W'(1);
                  j_in = i_ff + IDX_W'(3);
               end
            end else if ((i_ff == '0) && (j_next == n_idx)) begin
               j_in = j_next;
            end else begin
               step_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: addr_idx = i_ff;
               3'd1: addr_idx = i_ff + IDX_W'(1);
               3'd2: addr_idx = j_ff;
               default: addr_idx = (j_next == n_idx) ? '0 : j_next;
            endcase
            rd_en = (step_ff < 3'd4);
            case (step_ff)
               3'd1: begin p1x_in = rd_x; p1y_in = rd_y; end
               3'd2: begin p2x_in = rd_x; p2y_in = rd_y; end
               3'd3: begin q1x_in = rd_x; q1y_in = rd_y; end
               3'd4: begin
                  q2x_in = rd_x;
                  q2y_in = rd_y;
                  step_in = '0;
                  state_in = S_ORIENT;
               end
               default: ;
            endcase
         end
         S_ORIENT: begin
            step_in = step_ff + 3'd1;
            mac_req.tag = step_ff[2:1];
            if (!step_ff[0]) begin
               mac_req.u1 = ox; mac_req.u2 = ax; mac_req.v1 = oy; mac_req.v2 = by;
               mac_req.op = ACC_LOAD;
            end else begin
               mac_req.u1 = oy; mac_req.u2 = ay; mac_req.v1 = ox; mac_req.v2 = bx;
               mac_req.op = ACC_SUB;
               mac_req.capture = 1'b1;
            end
            if (step_ff == 3'd7) begin
               state_in = S_ORIENT_WAIT;
            end
         end
         S_ORIENT_WAIT: begin
            if (mac_rsp.done && (mac_rsp.tag == 2'd3)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (straddle || touch) begin
               status_in = ST_CROSS;
               state_in = S_RESULT;
            end else begin
               j_in = j_next;
               state_in = S_SCAN;
            end
         end
         S_RESULT: begin
            if (rsp_ch.ready) begin
               count_in = '0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Orientation results come back while later products are still issued.
      if (mac_rsp.done && ((state_ff == S_ORIENT) || (state_ff == S_ORIENT_WAIT))) begin
         dneg_in[mac_rsp.tag] = mac_rsp.acc[ACC_W-1];
         dzero_in[mac_rsp.tag] = (mac_rsp.acc == '0);
      end
   end

   assign rd_addr = addr_idx[AW-1:0];

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      step_ff <= step_in;
      i_ff <= i_in;
      j_ff <= j_in;
      status_ff <= status_in;
      area_ff <= area_in;
      prev_x_ff <= prev_x_in; prev_y_ff <= prev_y_in;
      cur_x_ff <= cur_x_in; cur_y_ff <= cur_y_in;
      first_x_ff <= first_x_in; first_y_ff <= first_y_in;
      p1x_ff <= p1x_in; p1y_ff <= p1y_in; p2x_ff <= p2x_in; p2y_ff <= p2y_in;
      q1x_ff <= q1x_in; q1y_ff <= q1y_in; q2x_ff <= q2x_in; q2y_ff <= q2y_in;
      dneg_ff <= dneg_in;
      dzero_ff <= dzero_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   // A product result only returns while the sequencer issues orientation products or waits for a result.
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mac_rsp.done |-> ((state_ff == S_ORIENT) || (state_ff == S_ORIENT_WAIT) ||
                        (state_ff == S_AREA_WAIT)))
      else $error("multiplier result arrived outside a wait");

   // The vertex count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   // A dropped vertex is only possible with a full store.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flagged with room in the store");
`endif
endmodule
